// ----- hdl/lidar_frame_parser_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser
// Implication checks, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_PARSER_TOP_MACROS_SVH
`define LIDAR_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define LFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lfp_pkg
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS       = 2'd3;

  localparam logic [15:0] STRENGTH_MIN_RST = 16'd100;
  localparam logic [15:0] DISTANCE_MAX_RST = 16'd1200;
  localparam logic [15:0] WINDOW_MS_RST    = 16'd200;
  localparam logic [9:0]  GAP_MS_RST       = 10'd20;

  localparam logic [7:0] HDR_BYTE = 8'h59;
  localparam logic [2:0] BODY_LAST = 3'd6;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_TICK = 1'b1;

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_ACCEPT  = 3'd1;
  localparam logic [2:0] ST_BAD_SUM = 3'd2;
  localparam logic [2:0] ST_LIMITS  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [15:0] strength_min;
    logic [15:0] distance_max;
    logic [15:0] window_ms;
    logic [9:0]  gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] distance;
    logic [15:0] strength;
    logic [15:0] held_distance;
  } result_t;

endpackage

// ----- hdl/lfp_cfg.sv -----
// ----------------------------------------------------------------------------
// lfp_cfg
// Configuration registers: limits and timer lengths, written by index.
// ----------------------------------------------------------------------------
module lfp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output lfp_pkg::cfg_t                  cfg
);
  import lfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength_min <= STRENGTH_MIN_RST;
      cfg.distance_max <= DISTANCE_MAX_RST;
      cfg.window_ms    <= WINDOW_MS_RST;
      cfg.gap_ms       <= GAP_MS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STRENGTH_MIN: cfg.strength_min <= cfg_data;
        REG_DISTANCE_MAX: cfg.distance_max <= cfg_data;
        REG_WINDOW_MS:    cfg.window_ms    <= cfg_data;
        REG_GAP_MS:       cfg.gap_ms       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/lfp_parser.sv -----
// ----------------------------------------------------------------------------
// lfp_parser
// Header hunt, body collection, checksum and limit checks, gap and window
// timers. Produces one result per word.
// ----------------------------------------------------------------------------
module lfp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             command,
  input  logic [7:0]       rx_byte,
  input  lfp_pkg::cfg_t    cfg,
  output lfp_pkg::result_t res
);
  import lfp_pkg::*;
  `include "lidar_frame_parser_top_macros.svh"

  logic [1:0]  phase, phase_next;
  logic [2:0]  body_count, body_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] distance_reg, distance_reg_next;
  logic [15:0] strength_reg, strength_reg_next;
  logic [9:0]  gap_timer, gap_timer_next;
  logic [15:0] window_timer, window_timer_next;
  logic [15:0] held_reg, held_reg_next;

  logic [15:0] window_inc;
  logic [9:0]  gap_inc;

  assign window_inc = window_timer + 16'd1;
  assign gap_inc    = gap_timer + 10'd1;

  always_comb begin
    phase_next        = phase;
    body_count_next   = body_count;
    running_sum_next  = running_sum;
    distance_reg_next = distance_reg;
    strength_reg_next = strength_reg;
    gap_timer_next    = gap_timer;
    window_timer_next = window_timer;
    held_reg_next     = held_reg;
    res.status        = ST_NONE;
    res.distance      = '0;
    res.strength      = '0;

    if (command == CMD_TICK) begin
      window_timer_next = window_inc;
      if (window_inc >= cfg.window_ms) begin
        window_timer_next = '0;
        phase_next        = PH_HUNT1;
        gap_timer_next    = '0;
        res.status        = ST_TIMEOUT;
      end else if (phase == PH_HUNT2 || phase == PH_BODY) begin
        gap_timer_next = gap_inc;
        if (gap_inc >= cfg.gap_ms) begin
          phase_next     = PH_HUNT1;
          gap_timer_next = '0;
        end
      end
    end else if (phase == PH_HUNT1) begin
      if (rx_byte == HDR_BYTE) begin
        phase_next     = PH_HUNT2;
        gap_timer_next = '0;
      end
    end else if (phase == PH_HUNT2) begin
      if (rx_byte == HDR_BYTE) begin
        phase_next       = PH_BODY;
        body_count_next  = '0;
        running_sum_next = HDR_BYTE + HDR_BYTE;
        gap_timer_next   = '0;
      end else begin
        phase_next = PH_HUNT1;
      end
    end else if (body_count >= BODY_LAST) begin
      phase_next      = PH_HUNT1;
      body_count_next = '0;
      gap_timer_next  = '0;
      res.distance    = distance_reg;
      res.strength    = strength_reg;
      if (running_sum != rx_byte) begin
        res.status = ST_BAD_SUM;
      end else if (strength_reg > cfg.strength_min && distance_reg < cfg.distance_max) begin
        res.status        = ST_ACCEPT;
        window_timer_next = '0;
        if (distance_reg != '0) held_reg_next = distance_reg;
      end else begin
        res.status = ST_LIMITS;
      end
    end else begin
      case (body_count)
        3'd0: distance_reg_next[7:0]  = rx_byte;
        3'd1: distance_reg_next[15:8] = rx_byte;
        3'd2: strength_reg_next[7:0]  = rx_byte;
        3'd3: strength_reg_next[15:8] = rx_byte;
        default: ;
      endcase
      running_sum_next = running_sum + rx_byte;
      body_count_next  = body_count + 3'd1;
    end

    res.held_distance = held_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT1;
      body_count   <= '0;
      running_sum  <= '0;
      distance_reg <= '0;
      strength_reg <= '0;
      gap_timer    <= '0;
      window_timer <= '0;
      held_reg     <= '0;
    end else if (step) begin
      phase        <= phase_next;
      body_count   <= body_count_next;
      running_sum  <= running_sum_next;
      distance_reg <= distance_reg_next;
      strength_reg <= strength_reg_next;
      gap_timer    <= gap_timer_next;
      window_timer <= window_timer_next;
      held_reg     <= held_reg_next;
    end
  end

  `LFP_ASSERT_NOW(a_count_bound, phase == PH_BODY, body_count <= BODY_LAST,
                  "body count past last byte")
  `LFP_ASSERT_NEXT(a_timeout_restart, step && res.status == ST_TIMEOUT,
                   phase == PH_HUNT1 && window_timer == 16'd0 && gap_timer == 10'd0,
                   "timeout did not restart hunt")
  `LFP_ASSERT_NEXT(a_accept_window, step && res.status == ST_ACCEPT,
                   window_timer == 16'd0 && phase == PH_HUNT1,
                   "accept did not clear window")

endmodule

// ----- hdl/lidar_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// lidar_frame_parser_top
// Nine-byte range-finder frame parser with input and result registers.
// ----------------------------------------------------------------------------
// Path: a word waits in the input register, then its result is held in the result register.
// Throughput: one word per cycle while results are taken; the result register frees as it is taken.
// The input register stalls only while the result register is full and held.
// Reset: synchronous; limits and timers return to defaults, hunt restarts,
// held distance clears.
module lidar_frame_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [15:0]                    distance,
  output logic [15:0]                    strength,
  output logic [15:0]                    held_distance
);
  import lfp_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_q;

  logic       in_full;
  logic       cmd_q;
  logic [7:0] byte_q;
  logic       advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  lfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .command (cmd_q),
    .rx_byte (byte_q),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) in_full <= 1'b1;
      else if (advance) in_full <= 1'b0;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q  <= command;
      byte_q <= rx_byte;
    end
    if (advance) res_q <= res;
  end

  assign status        = res_q.status;
  assign distance      = res_q.distance;
  assign strength      = res_q.strength;
  assign held_distance = res_q.held_distance;

endmodule
